/* hdl/tfss_pkg.sv */
// Shared types, constants and register codes for the tiered fuzzy string scorer.
// Used by every module of the block; depends on nothing else.
package tfss_pkg;

   localparam int MAX_PATTERN_DEF = 32;
   localparam int MAX_STRING_DEF  = 256;

   localparam int CHAR_W       = 8;
   localparam int POS_W        = 8;
   localparam int SCORE_W      = 17;
   localparam int PLEN_CFG_W   = 6;
   localparam int PAT_REGS     = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_IDX_W    = 3;
   localparam int PIDX_FULL_W  = 5;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 32;
   localparam int RSP_TUSER_W  = 2;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_CHARS_0_7   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_CHARS_8_15  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_CHARS_16_23 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_CHARS_24_31 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH      = 3'd4;

   localparam int SCORE_EXACT   = 100000;
   localparam int SCORE_PREFIX  = 50000;
   localparam int SCORE_SUBSTR  = 10000;
   localparam int PREFIX_STEP   = 100;
   localparam int SUBSTR_STEP   = 10;
   localparam int SUBSTR_PAT    = 5;
   localparam int SKIP_ADJ      = 15;
   localparam int SKIP_GAP      = 5;
   localparam int SKIP_SEP      = 10;
   localparam int SKIP_TAIL     = 2;
   localparam int SKIP_PAT      = 3;
   localparam int SKIP_LAST_RST = -2;

   localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CHAR_DOT        = 8'h2E;

   localparam int TUSER_POS_VALID = 0;
   localparam int TUSER_TOO_LONG  = 1;

   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_TOO_LONG,
      JOB_PREFIX,
      JOB_SUBSTRING,
      JOB_SKIP
   } job_kind_type;

   typedef struct packed {
      job_kind_type            kind;
      logic [SCORE_W-1:0]      score;
      logic [PLEN_CFG_W-1:0]   count;
      logic [POS_W-1:0]        start;
   } job_type;

   typedef struct packed {
      logic                    en;
      logic [QPTR_W-1:0]       slot;
      logic [PIDX_FULL_W-1:0]  idx;
      logic [POS_W-1:0]        pos;
   } pos_write_type;

   typedef struct packed {
      logic                    full;
      logic                    head_valid;
      logic [QPTR_W-1:0]       wr_slot;
      logic [QPTR_W-1:0]       rd_slot;
   } queue_status_type;

   typedef enum logic {
      FE_RUN,
      FE_FINISH
   } front_state_type;

endpackage

/* hdl/tfss_front.sv */
// Front end: pattern registers, per-character tier tracking and end-of-string scoring.
// Pushes one scored job per candidate into the job queue. Depends on tfss_pkg.
module tfss_front #(
   parameter int MAX_PATTERN = tfss_pkg::MAX_PATTERN_DEF,
   parameter int MAX_STRING  = tfss_pkg::MAX_STRING_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tfss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tfss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tfss_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   input  tfss_pkg::queue_status_type          q_status,
   output logic                                push_valid,
   output tfss_pkg::job_type                   push_job,
   output tfss_pkg::pos_write_type             pos_wr
);
   import tfss_pkg::*;

   localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
   localparam int CNT_W  = $clog2(MAX_STRING + 1);
   localparam int LAST_W = CNT_W + 1;
   localparam int SSC_W  = $clog2((SKIP_ADJ + SKIP_SEP) * MAX_PATTERN + 1);

   logic [CSR_DATA_W-1:0]  pat_ff [PAT_REGS];
   logic [CSR_DATA_W-1:0]  pat_in [PAT_REGS];
   logic [PLEN_CFG_W-1:0]  plen_cfg_ff, plen_cfg_in;
   front_state_type        state_ff, state_in;
   logic [CNT_W-1:0]       seen_ff, seen_in;
   logic                   prefix_ff, prefix_in;
   logic [MAX_PATTERN-1:0] vec_ff, vec_in;
   logic                   found_ff, found_in;
   logic [POS_W-1:0]       start_ff, start_in;
   logic [PLEN_W-1:0]      sidx_ff, sidx_in;
   logic [LAST_W-1:0]      last_ff, last_in;
   logic [SSC_W-1:0]       sscore_ff, sscore_in;
   logic [CHAR_W-1:0]      prev_ff, prev_in;
   logic                   ovf_ff, ovf_in;

   logic [CHAR_W-1:0]      pat_bytes [MAX_PATTERN];
   logic [PLEN_W-1:0]      plen;
   logic [MAX_PATTERN-1:0] eq;
   logic [CHAR_W-1:0]      c;
   job_type                job;

   assign c = req_tdata[CHAR_W-1:0];

   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pat_bytes[i] = pat_ff[(i >> 3) & (PAT_REGS - 1)][(i & 7) * CHAR_W +: CHAR_W];
      end
      if (plen_cfg_ff > PLEN_CFG_W'(MAX_PATTERN)) begin
         plen = PLEN_W'(MAX_PATTERN);
      end else begin
         plen = PLEN_W'(plen_cfg_ff);
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         eq[i] = (i < int'(plen)) && (pat_bytes[i] == c);
      end
   end

   always_comb begin
      logic [SCORE_W-1:0] n17;
      logic [SCORE_W-1:0] p17;
      n17 = SCORE_W'(seen_ff);
      p17 = SCORE_W'(plen);
      job.kind  = JOB_NONE;
      job.score = '0;
      job.count = PLEN_CFG_W'(1);
      job.start = '0;
      if (ovf_ff) begin
         job.kind = JOB_TOO_LONG;
      end else if (plen == '0) begin
         job.kind = JOB_NONE;
      end else if (prefix_ff && (n17 >= p17)) begin
         job.kind  = JOB_PREFIX;
         job.count = PLEN_CFG_W'(plen);
         if (n17 == p17) begin
            job.score = SCORE_W'(SCORE_EXACT);
         end else begin
            job.score = SCORE_W'(SCORE_PREFIX) + (n17 - p17) * SCORE_W'(PREFIX_STEP);
         end
      end else if (found_ff) begin
         job.kind  = JOB_SUBSTRING;
         job.count = PLEN_CFG_W'(plen);
         job.start = start_ff;
         job.score = SCORE_W'(SCORE_SUBSTR) + (n17 - SCORE_W'(start_ff)) * SCORE_W'(SUBSTR_STEP)
                     + p17 * SCORE_W'(SUBSTR_PAT);
      end else if (sidx_ff >= plen) begin
         job.kind  = JOB_SKIP;
         job.count = PLEN_CFG_W'(plen);
         job.score = SCORE_W'(sscore_ff) + (n17 - SCORE_W'(last_ff)) * SCORE_W'(SKIP_TAIL)
                     + p17 * SCORE_W'(SKIP_PAT);
      end
   end

   always_comb begin
      logic [MAX_PATTERN-1:0] vec_new;
      logic [PIDX_W-1:0]      plm1;
      logic                   adjacent;
      logic                   after_sep;
      logic [SSC_W-1:0]       gain;
      pat_in      = pat_ff;
      plen_cfg_in = plen_cfg_ff;
      state_in    = state_ff;
      seen_in     = seen_ff;
      prefix_in   = prefix_ff;
      vec_in      = vec_ff;
      found_in    = found_ff;
      start_in    = start_ff;
      sidx_in     = sidx_ff;
      last_in     = last_ff;
      sscore_in   = sscore_ff;
      prev_in     = prev_ff;
      ovf_in      = ovf_ff;
      push_valid  = 1'b0;
      push_job    = job;
      pos_wr      = '0;
      req_tready  = (state_ff == FE_RUN) && !q_status.full;
      vec_new     = ((vec_ff << 1) | MAX_PATTERN'(1)) & eq;
      plm1        = PIDX_W'(plen - PLEN_W'(1));
      adjacent    = ({1'b0, seen_ff} == (last_ff + LAST_W'(1)));
      after_sep   = (seen_ff != '0) && ((prev_ff == CHAR_UNDERSCORE) || (prev_ff == CHAR_DOT));
      gain        = (adjacent ? SSC_W'(SKIP_ADJ) : SSC_W'(SKIP_GAP))
                    + (after_sep ? SSC_W'(SKIP_SEP) : SSC_W'(0));

      if (csr_wr_en) begin
         case (csr_index)
            CSR_PATTERN_CHARS_0_7:   pat_in[0] = csr_wdata;
            CSR_PATTERN_CHARS_8_15:  pat_in[1] = csr_wdata;
            CSR_PATTERN_CHARS_16_23: pat_in[2] = csr_wdata;
            CSR_PATTERN_CHARS_24_31: pat_in[3] = csr_wdata;
            CSR_PATTERN_LENGTH:      plen_cfg_in = csr_wdata[PLEN_CFG_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         FE_RUN: begin
            if (req_tvalid && req_tready) begin
               if (!ovf_ff) begin
                  if (seen_ff >= CNT_W'(MAX_STRING)) begin
                     ovf_in = 1'b1;
                  end else begin
                     if ((seen_ff < CNT_W'(plen)) && (c != pat_bytes[PIDX_W'(seen_ff)])) begin
                        prefix_in = 1'b0;
                     end
                     vec_in = vec_new;
                     if ((plen != '0) && !found_ff && vec_new[plm1]) begin
                        found_in = 1'b1;
                        start_in = POS_W'(16'(seen_ff) + 16'd1 - 16'(plen));
                     end
                     if ((sidx_ff < plen) && (pat_bytes[PIDX_W'(sidx_ff)] == c)) begin
                        pos_wr.en   = 1'b1;
                        pos_wr.slot = q_status.wr_slot;
                        pos_wr.idx  = PIDX_FULL_W'(sidx_ff);
                        pos_wr.pos  = POS_W'(seen_ff);
                        sscore_in   = sscore_ff + gain;
                        last_in     = LAST_W'(seen_ff);
                        sidx_in     = sidx_ff + PLEN_W'(1);
                     end
                     prev_in = c;
                     seen_in = seen_ff + CNT_W'(1);
                  end
               end
               if (req_tlast) begin
                  state_in = FE_FINISH;
               end
            end
         end
         FE_FINISH: begin
            push_valid = 1'b1;
            state_in   = FE_RUN;
            seen_in    = '0;
            prefix_in  = 1'b1;
            vec_in     = '0;
            found_in   = 1'b0;
            start_in   = '0;
            sidx_in    = '0;
            last_in    = LAST_W'(SKIP_LAST_RST);
            sscore_in  = '0;
            prev_in    = '0;
            ovf_in     = 1'b0;
         end
         default: begin
            state_in = FE_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PAT_REGS; i++) begin
            pat_ff[i] <= '0;
         end
         plen_cfg_ff <= '0;
         state_ff    <= FE_RUN;
         seen_ff     <= '0;
         prefix_ff   <= 1'b1;
         vec_ff      <= '0;
         found_ff    <= 1'b0;
         start_ff    <= '0;
         sidx_ff     <= '0;
         last_ff     <= LAST_W'(SKIP_LAST_RST);
         sscore_ff   <= '0;
         prev_ff     <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         pat_ff      <= pat_in;
         plen_cfg_ff <= plen_cfg_in;
         state_ff    <= state_in;
         seen_ff     <= seen_in;
         prefix_ff   <= prefix_in;
         vec_ff      <= vec_in;
         found_ff    <= found_in;
         start_ff    <= start_in;
         sidx_ff     <= sidx_in;
         last_ff     <= last_in;
         sscore_ff   <= sscore_in;
         prev_ff     <= prev_in;
         ovf_ff      <= ovf_in;
      end
   end

   // A finished candidate always finds a free queue slot, since characters are only taken then.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == FE_FINISH |-> !q_status.full)
      else $error("front finished a candidate with the job queue full");

   assert property (@(posedge clock) disable iff (reset)
      sidx_ff <= PLEN_W'(MAX_PATTERN))
      else $error("skip index ran past the pattern");

endmodule

/* hdl/tfss_queue.sv */
// Two-entry job queue between the front and back ends.
// Its slot pointers also select the position bank each side uses. Depends on tfss_pkg.
module tfss_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   input  tfss_pkg::job_type           push_job,
   input  logic                        pop,
   output tfss_pkg::job_type           head_job,
   output tfss_pkg::queue_status_type  q_status
);
   import tfss_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type           job_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push_valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
      head_job            = job_ff[rd_ptr_ff];
      q_status.full       = (count_ff == CNT_W'(QUEUE_DEPTH));
      q_status.head_valid = (count_ff != '0);
      q_status.wr_slot    = wr_ptr_ff;
      q_status.rd_slot    = rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff != CNT_W'(QUEUE_DEPTH)))
      else $error("job pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job popped from an empty queue");

endmodule

/* hdl/tfss_back.sv */
// Back end: matched-position memory and the result run generator with its output register.
// Reads jobs from the job queue. Depends on tfss_pkg.
module tfss_back #(
   parameter int MAX_PATTERN = tfss_pkg::MAX_PATTERN_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tfss_pkg::pos_write_type             pos_wr,
   input  tfss_pkg::queue_status_type          q_status,
   input  tfss_pkg::job_type                   head_job,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tfss_pkg::SCORE_W-1:0]        rsp_score,
   output logic [tfss_pkg::POS_W-1:0]          rsp_position,
   output logic                                rsp_position_valid,
   output logic                                rsp_too_long,
   output logic                                rsp_tlast
);
   import tfss_pkg::*;

   localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [POS_W-1:0]      pos_mem_ff [QUEUE_DEPTH][MAX_PATTERN];

   logic [PLEN_CFG_W-1:0] cnt_ff, cnt_in;
   logic                  s1_valid_ff, s1_valid_in;
   job_kind_type          s1_kind_ff;
   logic [SCORE_W-1:0]    s1_score_ff;
   logic [POS_W-1:0]      s1_off_ff;
   logic                  s1_last_ff;
   logic [POS_W-1:0]      s1_pos_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]    rsp_score_ff;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic                  rsp_pv_ff, rsp_pv_in;
   logic                  rsp_tl_ff;
   logic                  rsp_last_ff;

   logic                  out_free;
   logic                  s1_adv;
   logic                  issue;
   logic                  last_item;
   logic [POS_W-1:0]      off_in;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_tready;
      s1_adv       = !s1_valid_ff || out_free;
      issue        = q_status.head_valid && s1_adv;
      last_item    = ((cnt_ff + PLEN_CFG_W'(1)) == head_job.count);
      pop          = issue && last_item;
      cnt_in       = cnt_ff;
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (issue) begin
         cnt_in = last_item ? '0 : cnt_ff + PLEN_CFG_W'(1);
      end
      if (s1_adv) begin
         s1_valid_in = issue;
      end
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
      if (head_job.kind == JOB_SUBSTRING) begin
         off_in = head_job.start + POS_W'(cnt_ff);
      end else begin
         off_in = POS_W'(cnt_ff);
      end
      case (s1_kind_ff)
         JOB_PREFIX, JOB_SUBSTRING: begin
            rsp_pos_in = s1_off_ff;
            rsp_pv_in  = 1'b1;
         end
         JOB_SKIP: begin
            rsp_pos_in = s1_pos_ff;
            rsp_pv_in  = 1'b1;
         end
         default: begin
            rsp_pos_in = '0;
            rsp_pv_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (pos_wr.en) begin
         pos_mem_ff[pos_wr.slot][PIDX_W'(pos_wr.idx)] <= pos_wr.pos;
      end
      if (issue) begin
         s1_pos_ff <= pos_mem_ff[q_status.rd_slot][PIDX_W'(cnt_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_kind_ff  <= head_job.kind;
         s1_score_ff <= head_job.score;
         s1_off_ff   <= off_in;
         s1_last_ff  <= last_item;
      end
      if (out_free && s1_valid_ff) begin
         rsp_score_ff <= s1_score_ff;
         rsp_pos_ff   <= rsp_pos_in;
         rsp_pv_ff    <= rsp_pv_in;
         rsp_tl_ff    <= (s1_kind_ff == JOB_TOO_LONG);
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid         = rsp_valid_ff;
   assign rsp_score          = rsp_score_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_position_valid = rsp_pv_ff;
   assign rsp_too_long       = rsp_tl_ff;
   assign rsp_tlast          = rsp_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      issue |-> (head_job.count != '0))
      else $error("job with an empty result run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pv_ff |-> rsp_last_ff && (rsp_score_ff == '0))
      else $error("no-match result is not a single zero-score transfer");

endmodule

/* hdl/tiered_fuzzy_string_scorer.sv */
// Top level of the tiered fuzzy string scorer: front end, job queue and back end.
// Depends on tfss_pkg, tfss_front, tfss_queue and tfss_back.
//
// The block takes one candidate character per cycle on the req_ channel while
// req_tready is high, and scores the candidate against the pattern in the csr_
// registers when the character flagged by req_tlast arrives. After that character
// the front end enters its finish state, in which the tier and score are settled
// and a job is queued. The back end then sends the result run on the rsp_ channel,
// one transfer per cycle while rsp_tready is high: one transfer per pattern
// character in use (pattern_length, at most MAX_PATTERN) for a match, one
// otherwise, each carrying the score. A two-job queue holds finished candidates, so
// the front end keeps taking characters while one job is queued; it stalls while
// two jobs are queued and in its finish state. No clearing pass follows reset.
module tiered_fuzzy_string_scorer #(
   parameter int MAX_PATTERN = tfss_pkg::MAX_PATTERN_DEF,
   parameter int MAX_STRING  = tfss_pkg::MAX_STRING_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [tfss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tfss_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tfss_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [7:0] candidate_char
   input  logic                                req_tlast,   // end_of_string
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tfss_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [16:0] score, [24:17] match_position
   output logic [tfss_pkg::RSP_TUSER_W-1:0]    rsp_tuser,   // [0] position_valid, [1] too_long
   output logic                                rsp_tlast    // last_of_run
);
   import tfss_pkg::*;

   queue_status_type   q_status;
   job_type            push_job;
   job_type            head_job;
   pos_write_type      pos_wr;
   logic               push_valid;
   logic               pop;
   logic [SCORE_W-1:0] rsp_score;
   logic [POS_W-1:0]   rsp_position;
   logic               rsp_position_valid;
   logic               rsp_too_long;

   tfss_front #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_STRING  (MAX_STRING)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pos_wr     (pos_wr)
   );

   tfss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .head_job   (head_job),
      .q_status   (q_status)
   );

   tfss_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .pos_wr             (pos_wr),
      .q_status           (q_status),
      .head_job           (head_job),
      .pop                (pop),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_score          (rsp_score),
      .rsp_position       (rsp_position),
      .rsp_position_valid (rsp_position_valid),
      .rsp_too_long       (rsp_too_long),
      .rsp_tlast          (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - SCORE_W - POS_W){1'b0}}, rsp_position, rsp_score};

   always_comb begin
      rsp_tuser                  = '0;
      rsp_tuser[TUSER_POS_VALID] = rsp_position_valid;
      rsp_tuser[TUSER_TOO_LONG]  = rsp_too_long;
   end

endmodule

/* tb/tiered_fuzzy_string_scorer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tiered_fuzzy_string_scorer: a directed table, one over-long
// candidate and random candidates are streamed in; each result is checked against an in-bench
// scorer or a pinned expected result. Depends on tfss_pkg and the tiered_fuzzy_string_scorer RTL.
module tiered_fuzzy_string_scorer_tb;
   import tfss_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int MAX_PATTERN   = MAX_PATTERN_DEF;
   localparam int MAX_STRING    = MAX_STRING_DEF;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int RANDOM_ITEMS  = 127;
   localparam int QUIET_AFTER   = 100;
   localparam int NUM_DIRECTED  = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_UNMAPPED = 3'd7;
   localparam logic [47:0] PATTERN_SET = "abcd_.";
   localparam logic [63:0] NOISE_SET   = "abcdxy_.";

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [POS_W-1:0]   position;
      logic               position_valid;
      logic               too_long;
      logic               last_of_run;
   } match_result_type;

   typedef struct packed {
      logic             on;
      match_result_type result;
   } pinned_result_type;

   typedef enum {ROW_WRITE, ROW_BYTE, ROW_SETTLE} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_IDX_W-1:0]   index;
      logic [CSR_DATA_W-1:0]  data;
      logic [CHAR_W-1:0]      ch;
      logic                   last;
      pinned_result_type      pin;
   } stim_row_type;

   typedef enum {
      SHAPE_EXACT,
      SHAPE_PREFIX,
      SHAPE_SUBSTRING,
      SHAPE_SKIP,
      SHAPE_BROKEN,
      SHAPE_NOISE
   } cand_shape_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata = '0;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;
   logic                    rsp_tlast;

   tiered_fuzzy_string_scorer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Scorer state: pattern registers and the candidate in progress.
   logic [CSR_DATA_W-1:0] pat_reg [PAT_REGS];
   logic [PLEN_CFG_W-1:0] pat_len_reg;
   int unsigned           cand_len;
   bit                    prefix_ok;
   logic [31:0]           sub_vec;
   bit                    sub_hit;
   logic [POS_W-1:0]      sub_start;
   int unsigned           skip_next;
   int                    skip_prev;
   int unsigned           skip_sum;
   logic [POS_W-1:0]      skip_at [MAX_PATTERN];
   logic [CHAR_W-1:0]     prev_byte;
   bit                    overflowed;

   match_result_type  pending_scores [$];
   pinned_result_type presented_pins [$];
   int unsigned       errors;
   int unsigned       cycle_count;
   int unsigned       req_gap_pct;
   int unsigned       rsp_stall_pct;
   int unsigned       rsp_hold;
   bit                quiet;

   function automatic logic [CHAR_W-1:0] pat_byte(input int unsigned i);
      return pat_reg[i / 8][(i % 8) * 8 +: 8];
   endfunction

   function automatic int unsigned active_len();
      return (pat_len_reg > MAX_PATTERN) ? MAX_PATTERN : pat_len_reg;
   endfunction

   task automatic start_candidate();
      cand_len = 0;
      prefix_ok = 1'b1;
      sub_vec = '0;
      sub_hit = 1'b0;
      sub_start = '0;
      skip_next = 0;
      skip_prev = SKIP_LAST_RST;
      skip_sum = 0;
      prev_byte = '0;
      overflowed = 1'b0;
   endtask

   task automatic score_byte(input logic [CHAR_W-1:0] c, input logic last,
                             output match_result_type run [$]);
      int unsigned      plen;
      int unsigned      idx;
      int unsigned      total;
      logic [31:0]      eq;
      job_kind_type     tier;
      match_result_type r;
      run = {};
      plen = active_len();
      if (!overflowed) begin
         if (cand_len >= MAX_STRING) begin
            overflowed = 1'b1;
         end else begin
            idx = cand_len;
            if (idx < plen && c != pat_byte(idx)) prefix_ok = 1'b0;
            eq = '0;
            for (int i = 0; i < plen; i++) begin
               if (pat_byte(i) == c) eq[i] = 1'b1;
            end
            sub_vec = ((sub_vec << 1) | 32'd1) & eq;
            if (plen > 0 && !sub_hit && sub_vec[plen - 1]) begin
               sub_hit = 1'b1;
               sub_start = 8'(idx - (plen - 1));
            end
            if (skip_next < plen && pat_byte(skip_next) == c) begin
               skip_at[skip_next] = 8'(idx);
               skip_sum += (int'(idx) == skip_prev + 1) ? SKIP_ADJ : SKIP_GAP;
               if (idx > 0 && (prev_byte == CHAR_UNDERSCORE || prev_byte == CHAR_DOT)) begin
                  skip_sum += SKIP_SEP;
               end
               skip_prev = idx;
               skip_next++;
            end
            prev_byte = c;
            cand_len = idx + 1;
         end
      end
      if (last) begin
         r = '0;
         r.last_of_run = 1'b1;
         tier = JOB_NONE;
         total = 0;
         if (overflowed) begin
            tier = JOB_TOO_LONG;
         end else if (plen != 0) begin
            if (prefix_ok && cand_len >= plen) begin
               tier = JOB_PREFIX;
               total = (cand_len == plen) ? SCORE_EXACT
                     : SCORE_PREFIX + (cand_len - plen) * PREFIX_STEP;
            end else if (sub_hit) begin
               tier = JOB_SUBSTRING;
               total = SCORE_SUBSTR + (cand_len - sub_start) * SUBSTR_STEP + plen * SUBSTR_PAT;
            end else if (skip_next >= plen) begin
               tier = JOB_SKIP;
               total = skip_sum + (cand_len - skip_prev) * SKIP_TAIL + plen * SKIP_PAT;
            end
         end
         if (tier == JOB_TOO_LONG) begin
            r.too_long = 1'b1;
            run = {run, r};
         end else if (tier == JOB_NONE) begin
            run = {run, r};
         end else begin
            for (int i = 0; i < plen; i++) begin
               r.score = total[SCORE_W-1:0];
               r.position = (tier == JOB_PREFIX) ? 8'(i)
                          : (tier == JOB_SUBSTRING) ? 8'(sub_start + i) : skip_at[i];
               r.position_valid = 1'b1;
               r.last_of_run = (i == plen - 1);
               run = {run, r};
            end
         end
         start_candidate();
      end
   endtask

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      match_result_type  run [$];
      match_result_type  want;
      match_result_type  got;
      pinned_result_type pin;
      if (!reset) begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PATTERN_CHARS_0_7:   pat_reg[0] = csr_wdata;
               CSR_PATTERN_CHARS_8_15:  pat_reg[1] = csr_wdata;
               CSR_PATTERN_CHARS_16_23: pat_reg[2] = csr_wdata;
               CSR_PATTERN_CHARS_24_31: pat_reg[3] = csr_wdata;
               CSR_PATTERN_LENGTH:      pat_len_reg = csr_wdata[PLEN_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            pin = presented_pins.pop_front();
            score_byte(req_tdata[CHAR_W-1:0], req_tlast, run);
            if (pin.on) begin
               pending_scores = {pending_scores, pin.result};
            end else begin
               foreach (run[k]) pending_scores = {pending_scores, run[k]};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.score = rsp_tdata[SCORE_W-1:0];
            got.position = rsp_tdata[SCORE_W +: POS_W];
            got.position_valid = rsp_tuser[TUSER_POS_VALID];
            got.too_long = rsp_tuser[TUSER_TOO_LONG];
            got.last_of_run = rsp_tlast;
            if (pending_scores.size() == 0) begin
               $display("%0t: unexpected result transfer, score %0d position %0d",
                        $time, got.score, got.position);
               errors++;
            end else begin
               want = pending_scores.pop_front();
               check_field("score", want.score, got.score);
               check_field("match_position", want.position, got.position);
               check_field("position_valid", want.position_valid, got.position_valid);
               check_field("too_long", want.too_long, got.too_long);
               check_field("last_of_run", want.last_of_run, got.last_of_run);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= (rsp_hold == 1);
      end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_hold <= $urandom_range(1, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout with %0d results outstanding", $time, pending_scores.size());
      $display("tiered_fuzzy_string_scorer_tb: FAIL");
      $finish;
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last,
                            input pinned_result_type pin);
      if (!quiet && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tdata <= c;
      req_tlast <= last;
      req_tvalid <= 1'b1;
      presented_pins = {presented_pins, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (presented_pins.size() != 0 || pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pinned_result_type pin_of(input int unsigned score, input logic valid,
                                                input logic too_long);
      pinned_result_type p;
      p = '0;
      p.on = 1'b1;
      p.result.score = score[SCORE_W-1:0];
      p.result.position_valid = valid;
      p.result.too_long = too_long;
      p.result.last_of_run = 1'b1;
      return p;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_IDX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '{kind: ROW_WRITE, index: index, data: value, ch: '0, last: 1'b0, pin: '0};
      return row;
   endfunction

   function automatic stim_row_type byte_row(input logic [CHAR_W-1:0] c, input logic last);
      stim_row_type row;
      row = '{kind: ROW_BYTE, index: '0, data: '0, ch: c, last: last, pin: '0};
      return row;
   endfunction

   function automatic stim_row_type pinned_row(input logic [CHAR_W-1:0] c,
                                               input pinned_result_type pin);
      stim_row_type row;
      row = '{kind: ROW_BYTE, index: '0, data: '0, ch: c, last: 1'b1, pin: pin};
      return row;
   endfunction

   function automatic stim_row_type settle_row();
      stim_row_type row;
      row = '{kind: ROW_SETTLE, index: '0, data: '0, ch: '0, last: 1'b0, pin: '0};
      return row;
   endfunction

   function automatic logic [CHAR_W-1:0] noise_byte();
      if ($urandom_range(0, 99) < 35) return 8'($urandom_range(0, 255));
      return NOISE_SET[8 * $urandom_range(0, 7) +: 8];
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pattern_word();
      logic [CSR_DATA_W-1:0] w;
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      for (int i = 0; i < 8; i++) w[8 * i +: 8] = PATTERN_SET[8 * $urandom_range(0, 5) +: 8];
      return w;
   endfunction

   function automatic logic [PLEN_CFG_W-1:0] pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 50) return 6'($urandom_range(1, 4));
      if (r < 80) return 6'($urandom_range(5, 12));
      if (r < 90) return 6'($urandom_range(MAX_PATTERN - 1, MAX_PATTERN));
      return 6'($urandom_range(MAX_PATTERN + 1, 2 ** PLEN_CFG_W - 1));
   endfunction

   task automatic build_candidate(output logic [CHAR_W-1:0] text [$]);
      int unsigned    plen;
      int unsigned    r;
      int unsigned    k;
      cand_shape_type shape;
      text = {};
      plen = active_len();
      r = $urandom_range(0, 99);
      if (plen == 0 || r >= 85) shape = SHAPE_NOISE;
      else if (r < 15) shape = SHAPE_EXACT;
      else if (r < 30) shape = SHAPE_PREFIX;
      else if (r < 50) shape = SHAPE_SUBSTRING;
      else if (r < 70) shape = SHAPE_SKIP;
      else shape = SHAPE_BROKEN;
      if (shape == SHAPE_SUBSTRING) begin
         repeat ($urandom_range(1, 4)) text = {text, noise_byte()};
      end
      for (int i = 0; i < plen && shape != SHAPE_NOISE; i++) begin
         if (shape == SHAPE_SKIP) begin
            repeat ($urandom_range(0, 2)) text = {text, noise_byte()};
         end
         text = {text, pat_byte(i)};
      end
      case (shape)
         SHAPE_PREFIX: begin
            repeat ($urandom_range(1, 4)) text = {text, noise_byte()};
         end
         SHAPE_SUBSTRING, SHAPE_SKIP: begin
            repeat ($urandom_range(0, 3)) text = {text, noise_byte()};
         end
         SHAPE_BROKEN: begin
            k = $urandom_range(0, plen - 1);
            r = $urandom_range(0, 2);
            if (r == 0) text[k] = noise_byte();
            else if (r == 1) text.delete(k);
            else while (text.size() > k) text.delete(text.size() - 1);
         end
         SHAPE_NOISE: begin
            repeat ($urandom_range(1, 8)) text = {text, noise_byte()};
         end
         default: ;
      endcase
      if (text.size() == 0) text = {text, noise_byte()};
   endtask

   initial begin
      stim_row_type          directed [NUM_DIRECTED];
      logic [CHAR_W-1:0]     text [$];
      logic [CSR_DATA_W-1:0] value;
      int unsigned           random_sent;
      int unsigned           n_cands;

      foreach (pat_reg[i]) pat_reg[i] = '0;
      pat_len_reg = '0;
      start_candidate();
      errors = 0;
      cycle_count = 0;
      rsp_hold = 0;
      quiet = 1'b0;
      req_gap_pct = 25;
      rsp_stall_pct = 20;

      directed = '{
         pinned_row("a", pin_of(0, 1'b0, 1'b0)),
         settle_row(),
         reg_row(CSR_PATTERN_CHARS_0_7, 64'hFFFF_FFFF_FF63_6261),
         reg_row(CSR_PATTERN_LENGTH, 64'd3),
         byte_row("a", 1'b0), byte_row("b", 1'b0), byte_row("c", 1'b1),
         byte_row("a", 1'b0), byte_row("b", 1'b0), byte_row("c", 1'b0), byte_row("z", 1'b1),
         byte_row("z", 1'b0), byte_row("a", 1'b0), byte_row("b", 1'b0), byte_row("c", 1'b0),
         byte_row("z", 1'b1),
         byte_row("a", 1'b0), byte_row("_", 1'b0), byte_row("b", 1'b0), byte_row(".", 1'b0),
         byte_row("c", 1'b1),
         byte_row("a", 1'b0),
         pinned_row("b", pin_of(0, 1'b0, 1'b0)),
         settle_row(),
         reg_row(CSR_PATTERN_LENGTH, 64'd1),
         pinned_row("a", pin_of(SCORE_EXACT, 1'b1, 1'b0)),
         pinned_row(8'hFF, pin_of(0, 1'b0, 1'b0)),
         settle_row(),
         reg_row(CSR_INDEX_UNMAPPED, 64'h0123_4567_89AB_CDEF),
         pinned_row(8'h00, pin_of(0, 1'b0, 1'b0)),
         byte_row("q", 1'b0),
         settle_row(),
         reg_row(CSR_PATTERN_CHARS_0_7, 64'h0000_0000_0000_0078),
         byte_row("x", 1'b1),
         settle_row(),
         reg_row(CSR_PATTERN_CHARS_8_15, 64'h5555_AAAA_0F0F_F0F0),
         reg_row(CSR_PATTERN_CHARS_16_23, 64'h3C3C_C3C3_9669_6996),
         reg_row(CSR_PATTERN_CHARS_24_31, 64'h8000_0000_0000_0001),
         reg_row(CSR_PATTERN_LENGTH, 64'd63),
         byte_row(8'h80, 1'b1)
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[k]) begin
         case (directed[k].kind)
            ROW_WRITE:  write_reg(directed[k].index, directed[k].data);
            ROW_BYTE:   send_byte(directed[k].ch, directed[k].last, directed[k].pin);
            ROW_SETTLE: settle();
            default: ;
         endcase
      end

      // One byte more than the longest legal candidate.
      settle();
      write_reg(CSR_PATTERN_CHARS_0_7, pattern_word());
      write_reg(CSR_PATTERN_LENGTH, 64'd2);
      for (int n = 0; n <= MAX_STRING; n++) begin
         send_byte(noise_byte(), n == MAX_STRING,
                   (n == MAX_STRING) ? pin_of(0, 1'b0, 1'b1) : pinned_result_type'('0));
      end

      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 2))
            0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_gap_pct = 15; rsp_stall_pct = 15; end
            default: begin req_gap_pct = 40; rsp_stall_pct = 40; end
         endcase
         for (int r = 0; r < PAT_REGS; r++) begin
            if ($urandom_range(0, 99) < 40) write_reg(3'(CSR_PATTERN_CHARS_0_7 + r), pattern_word());
         end
         if ($urandom_range(0, 99) < 60) begin
            value = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0) value = '0;
            value[PLEN_CFG_W-1:0] = pick_length();
            write_reg(CSR_PATTERN_LENGTH, value);
         end
         if ($urandom_range(0, 99) < 5) write_reg(CSR_INDEX_UNMAPPED, {$urandom, $urandom});
         n_cands = $urandom_range(1, 6);
         for (int j = 0; j < n_cands && random_sent < RANDOM_ITEMS; j++) begin
            build_candidate(text);
            foreach (text[i]) begin
               quiet = (random_sent >= QUIET_AFTER);
               send_byte(text[i], i == text.size() - 1, '0);
               random_sent++;
            end
         end
      end

      settle();
      if (errors == 0 && pending_scores.size() == 0) begin
         $display("tiered_fuzzy_string_scorer_tb: PASS");
      end else begin
         $display("tiered_fuzzy_string_scorer_tb: FAIL");
      end
      $finish;
   end

endmodule
